// File: hw/rtl/tid_pkg.sv
// ----------------------------------------------------------------------------
// tid_pkg
// Shared widths, register indexes and limits for the thread index decomposer.
// ----------------------------------------------------------------------------
package tid_pkg;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgGridWidth   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgGridHeight  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgBlockWidth  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgBlockHeight = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgBlockDepth  = 3'd4;

  // dimension widths
  localparam int unsigned GridDimW = 16;
  localparam int unsigned BlkDimW  = 11;
  localparam int unsigned BlkDepW  = 7;
  localparam int unsigned BwBhW    = 21;
  localparam int unsigned TpbW     = 27;

  // clamp limits of the block dimensions
  localparam logic [BlkDimW-1:0] BlkDimMax = 11'd1024;
  localparam logic [BlkDepW-1:0] BlkDepMax = 7'd64;

  // field widths
  localparam int unsigned FlatW  = 32;
  localparam int unsigned TibW   = 26;
  localparam int unsigned ThrXYW = 10;
  localparam int unsigned ThrZW  = 6;
  localparam int unsigned WarpW  = 21;
  localparam int unsigned LaneW  = 5;
  localparam int unsigned OutW   = 152;

  // cycles the input stays closed after a configuration write
  localparam logic [1:0] CfgSettle = 2'd2;

endpackage

// File: hw/rtl/tid_div.sv
// ----------------------------------------------------------------------------
// tid_div
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// that travels alongside the operands.
// ----------------------------------------------------------------------------
module tid_div #(
  parameter int unsigned DW = 32,
  parameter int unsigned VW = 16,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  input  logic [SW-1:0] side_i,
  output logic [DW-1:0] quo_o,
  output logic [VW-1:0] rem_o,
  output logic [SW-1:0] side_o
);

  logic [VW-1:0] rem_q  [DW];
  logic [VW-1:0] rem_d  [DW];
  logic [DW-1:0] dq_q   [DW];
  logic [DW-1:0] dq_d   [DW];
  logic [SW-1:0] side_q [DW];
  logic [SW-1:0] side_d [DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [VW-1:0] rem_in;
    logic [DW-1:0] dq_in;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in    = '0;
      assign dq_in     = dividend_i;
      assign side_d[k] = side_i;
    end else begin : g_next
      assign rem_in    = rem_q[k-1];
      assign dq_in     = dq_q[k-1];
      assign side_d[k] = side_q[k-1];
    end

    // shift in the next dividend bit, subtract when it fits
    assign trial    = {rem_in, dq_in[DW-1]};
    assign diff     = trial - {1'b0, divisor_i};
    assign ge       = trial >= {1'b0, divisor_i};
    assign rem_d[k] = ge ? diff[VW-1:0] : trial[VW-1:0];
    assign dq_d[k]  = {dq_in[DW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      dq_q  <= dq_d;
    end
  end

  // sideband carries the valid bit, so it is cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DW; i++) begin
        side_q[i] <= '0;
      end
    end else if (en_i) begin
      side_q <= side_d;
    end
  end

  assign quo_o  = dq_q[DW-1];
  assign rem_o  = rem_q[DW-1];
  assign side_o = side_q[DW-1];

endmodule

// File: hw/rtl/thread_index_decomposer.sv
// ----------------------------------------------------------------------------
// thread_index_decomposer
// Splits a flat global thread number into block and thread coordinates,
// warp number and lane, using the configured grid and block dimensions.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid_i/s_axis_tready_o  flat_thread
//  m_axis    out  m_axis_tvalid_o/m_axis_tready_i  coordinates, warp, lane
//  cfg       in   cfg_valid_i/cfg_ready_o          cfg_index_i, cfg_data_i
//
//  one item per cycle unless the output holds or a config write settles;
//  items pass three chained 32-stage dividers and the output register
//  reset sets every dimension to 1 and empties the pipeline
//  while a result waits with m_axis_tready_i low the whole pipeline holds
//  a configuration write closes the input while the
//  threads-per-block product is rebuilt
// ----------------------------------------------------------------------------
module thread_index_decomposer #(
  parameter int unsigned WARP_SIZE = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // [31:0] flat_thread
  input  logic [31:0]                 s_axis_tdata_i,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // [15:0] blk_x, [31:16] blk_y, [63:32] blk_z, [73:64] thr_x, [83:74] thr_y,
  // [89:84] thr_z, [110:90] warp_number, [115:111] lane_number,
  // [147:116] global_number, [151:148] zero
  output logic [tid_pkg::OutW-1:0]    m_axis_tdata_o,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tid_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [tid_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned WsW       = $clog2(WARP_SIZE + 1);
  localparam int unsigned FW        = tid_pkg::FlatW;
  localparam int unsigned WarpLog   = $clog2(WARP_SIZE);
  localparam int unsigned WarpShift = tid_pkg::TibW + WarpLog;
  localparam int unsigned RecipW    = tid_pkg::TibW + 1;
  localparam int unsigned ProdW     = tid_pkg::TibW + RecipW;
  localparam int unsigned BwSideW   = tid_pkg::WarpW + tid_pkg::TibW;
  localparam int unsigned BhSideW   = tid_pkg::GridDimW + WsW + tid_pkg::WarpW +
                                      tid_pkg::ThrXYW;
  // rounded-up reciprocal, exact for every thread number inside a block
  localparam logic [RecipW-1:0] WarpRecip =
    RecipW'(((64'd1 << WarpShift) + 64'(WARP_SIZE) - 64'd1) / 64'(WARP_SIZE));

  // ---------------------------------------------------------------- config
  logic [tid_pkg::GridDimW-1:0] gw_q, gh_q;
  logic [tid_pkg::BlkDimW-1:0]  bw_q, bh_q;
  logic [tid_pkg::BlkDepW-1:0]  bd_q;
  logic [tid_pkg::BwBhW-1:0]    bwbh_q, bwbh_d;
  logic [tid_pkg::TpbW-1:0]     tpb_q, tpb_d;
  logic [1:0]                   settle_q;
  logic                         cfg_wr;
  logic [tid_pkg::GridDimW-1:0] grid_val;
  logic [tid_pkg::BlkDimW-1:0]  bdim_val;
  logic [tid_pkg::BlkDepW-1:0]  bdep_val;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  // zero acts as one, oversized block dimensions are clamped
  always_comb begin
    grid_val = (cfg_data_i == '0) ? tid_pkg::GridDimW'(1) : cfg_data_i;
    bdim_val = cfg_data_i[tid_pkg::BlkDimW-1:0];
    if (bdim_val == '0) begin
      bdim_val = tid_pkg::BlkDimW'(1);
    end else if (bdim_val > tid_pkg::BlkDimMax) begin
      bdim_val = tid_pkg::BlkDimMax;
    end
    bdep_val = cfg_data_i[tid_pkg::BlkDepW-1:0];
    if (bdep_val == '0) begin
      bdep_val = tid_pkg::BlkDepW'(1);
    end else if (bdep_val > tid_pkg::BlkDepMax) begin
      bdep_val = tid_pkg::BlkDepMax;
    end
  end

  assign bwbh_d = {10'b0, bw_q} * {10'b0, bh_q};
  assign tpb_d  = {6'b0, bwbh_q} * {20'b0, bd_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q     <= tid_pkg::GridDimW'(1);
      gh_q     <= tid_pkg::GridDimW'(1);
      bw_q     <= tid_pkg::BlkDimW'(1);
      bh_q     <= tid_pkg::BlkDimW'(1);
      bd_q     <= tid_pkg::BlkDepW'(1);
      bwbh_q   <= tid_pkg::BwBhW'(1);
      tpb_q    <= tid_pkg::TpbW'(1);
      settle_q <= '0;
    end else begin
      bwbh_q <= bwbh_d;
      tpb_q  <= tpb_d;
      if (cfg_wr) begin
        settle_q <= tid_pkg::CfgSettle;
        case (cfg_index_i)
          tid_pkg::CfgGridWidth:   gw_q <= grid_val;
          tid_pkg::CfgGridHeight:  gh_q <= grid_val;
          tid_pkg::CfgBlockWidth:  bw_q <= bdim_val;
          tid_pkg::CfgBlockHeight: bh_q <= bdim_val;
          tid_pkg::CfgBlockDepth:  bd_q <= bdep_val;
          default: ;
        endcase
      end else if (settle_q != '0) begin
        settle_q <= settle_q - 2'd1;
      end
    end
  end

  // -------------------------------------------------------------- pipeline
  logic en, acc;
  logic out_valid_q;

  assign en              = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en && (settle_q == '0);
  assign acc             = s_axis_tvalid_i && s_axis_tready_o;

  // level 1: flat / threads per block
  logic [FW-1:0]            blk;
  logic [tid_pkg::TpbW-1:0] tib_r;
  logic [FW:0]              side1;

  tid_div #(.DW(FW), .VW(tid_pkg::TpbW), .SW(FW + 1)) u_div_tpb (
    .clk_i, .rst_ni, .en_i(en),
    .dividend_i(s_axis_tdata_i), .divisor_i(tpb_q), .side_i({acc, s_axis_tdata_i}),
    .quo_o(blk), .rem_o(tib_r), .side_o(side1)
  );

  logic [tid_pkg::TibW-1:0] tib;
  assign tib = tib_r[tid_pkg::TibW-1:0];

  // level 2: block number by grid width, thread in block by block width
  logic [FW-1:0]              blk_gw;
  logic [tid_pkg::GridDimW-1:0] bx2;
  logic [FW:0]                side2;
  logic [FW-1:0]              tib_bw;
  logic [tid_pkg::BlkDimW-1:0]  tx2;
  logic [tid_pkg::TibW-1:0]   tib2;
  logic [ProdW-1:0]           warp_prod;
  logic [tid_pkg::WarpW-1:0]  warp1, warp2;
  logic [BwSideW-1:0]         side_bw;

  // warp number by reciprocal multiplication, carried beside the thread number
  assign warp_prod = {{RecipW{1'b0}}, tib} * {{tid_pkg::TibW{1'b0}}, WarpRecip};
  assign warp1     = warp_prod[WarpShift +: tid_pkg::WarpW];

  tid_div #(.DW(FW), .VW(tid_pkg::GridDimW), .SW(FW + 1)) u_div_gw (
    .clk_i, .rst_ni, .en_i(en),
    .dividend_i(blk), .divisor_i(gw_q), .side_i(side1),
    .quo_o(blk_gw), .rem_o(bx2), .side_o(side2)
  );

  tid_div #(.DW(FW), .VW(tid_pkg::BlkDimW), .SW(BwSideW)) u_div_bw (
    .clk_i, .rst_ni, .en_i(en),
    .dividend_i({6'b0, tib}), .divisor_i(bw_q), .side_i({warp1, tib}),
    .quo_o(tib_bw), .rem_o(tx2), .side_o(side_bw)
  );

  assign tib2  = side_bw[tid_pkg::TibW-1:0];
  assign warp2 = side_bw[tid_pkg::TibW +: tid_pkg::WarpW];

  // level 3: grid height and block height, lane from the low bits
  logic [FW-1:0]                blk_z;
  logic [tid_pkg::GridDimW-1:0] blk_y;
  logic [FW:0]                  side3;
  logic [FW-1:0]                tz_quo;
  logic [tid_pkg::BlkDimW-1:0]  ty_r;
  logic [tid_pkg::ThrXYW-1:0]   thr_x;
  logic [tid_pkg::WarpW-1:0]    warp;
  logic [WsW-1:0]               lane;
  logic [tid_pkg::GridDimW-1:0] blk_x;
  logic [WsW-1:0]               warp_mul, lane3;
  logic [BhSideW-1:0]           side_bh;

  // the lane is below the warp size, so only the low bits take part
  assign warp_mul = warp2[WsW-1:0] * WsW'(WARP_SIZE);
  assign lane3    = tib2[WsW-1:0] - warp_mul;

  tid_div #(.DW(FW), .VW(tid_pkg::GridDimW), .SW(FW + 1)) u_div_gh (
    .clk_i, .rst_ni, .en_i(en),
    .dividend_i(blk_gw), .divisor_i(gh_q), .side_i(side2),
    .quo_o(blk_z), .rem_o(blk_y), .side_o(side3)
  );

  tid_div #(.DW(FW), .VW(tid_pkg::BlkDimW), .SW(BhSideW)) u_div_bh (
    .clk_i, .rst_ni, .en_i(en),
    .dividend_i(tib_bw), .divisor_i(bh_q),
    .side_i({bx2, lane3, warp2, tx2[tid_pkg::ThrXYW-1:0]}),
    .quo_o(tz_quo), .rem_o(ty_r), .side_o(side_bh)
  );

  assign thr_x = side_bh[tid_pkg::ThrXYW-1:0];
  assign warp  = side_bh[tid_pkg::ThrXYW +: tid_pkg::WarpW];
  assign lane  = side_bh[tid_pkg::ThrXYW + tid_pkg::WarpW +: WsW];
  assign blk_x = side_bh[tid_pkg::ThrXYW + tid_pkg::WarpW + WsW +: tid_pkg::GridDimW];

  // ---------------------------------------------------------------- output
  logic [tid_pkg::GridDimW-1:0] o_bx_q, o_by_q;
  logic [FW-1:0]                o_bz_q, o_glob_q;
  logic [tid_pkg::ThrXYW-1:0]   o_tx_q, o_ty_q;
  logic [tid_pkg::ThrZW-1:0]    o_tz_q;
  logic [tid_pkg::WarpW-1:0]    o_warp_q;
  logic [tid_pkg::LaneW-1:0]    o_lane_q;
  logic [WsW-1:0]               o_lane_full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= side3[FW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_bx_q        <= blk_x;
      o_by_q        <= blk_y;
      o_bz_q        <= blk_z;
      o_tx_q        <= thr_x;
      o_ty_q        <= ty_r[tid_pkg::ThrXYW-1:0];
      o_tz_q        <= tz_quo[tid_pkg::ThrZW-1:0];
      o_warp_q      <= warp;
      o_lane_q      <= tid_pkg::LaneW'(lane);
      o_lane_full_q <= lane;
      o_glob_q      <= side3[FW-1:0];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0, o_glob_q, o_lane_q, o_warp_q, o_tz_q, o_ty_q, o_tx_q,
                            o_bz_q, o_by_q, o_bx_q};

  // ------------------------------------------------------------ assertions
  a_blk_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> o_bx_q < gw_q)
    else $error("blk_x not below grid width");

  a_thr_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> {1'b0, o_tx_q} < bw_q)
    else $error("thr_x not below block width");

  a_lane_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> o_lane_full_q < WsW'(WARP_SIZE))
    else $error("lane not below warp size");

  a_tpb_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    settle_q == '0 |-> tpb_q == tpb_d)
    else $error("threads per block product stale while input open");

endmodule

// File: tb/sv/thread_index_decomposer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thread_index_decomposer_tb
// Streams flat thread numbers through the decomposer under many grid and
// block settings and checks every coordinate field of each result against
// an in-bench model, with random idling on both sides of the stream.
// ----------------------------------------------------------------------------
module thread_index_decomposer_tb;

  localparam int unsigned WarpSize      = 32;
  localparam int unsigned NumIdx        = 1 << tid_pkg::CfgIdxW;
  localparam int unsigned FirstUnusedIdx = tid_pkg::CfgBlockDepth + 1;
  localparam int unsigned NumPhases     = 24;
  localparam int unsigned ItemsPerPhase = 80;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned TailCycles    = 120;
  localparam int unsigned CycleLimit    = 400_000;

  // result layout, msb first
  typedef struct packed {
    logic [3:0]  pad;
    logic [31:0] global_number;
    logic [4:0]  lane_number;
    logic [20:0] warp_number;
    logic [5:0]  thr_z;
    logic [9:0]  thr_y;
    logic [9:0]  thr_x;
    logic [31:0] blk_z;
    logic [15:0] blk_y;
    logic [15:0] blk_x;
  } coords_t;

  class decomp_board;
    logic [15:0] grid_w = 16'd1;
    logic [15:0] grid_h = 16'd1;
    logic [10:0] blk_w  = 11'd1;
    logic [10:0] blk_h  = 11'd1;
    logic [6:0]  blk_d  = 7'd1;
    coords_t     expected_coords[$];
    int unsigned checked    = 0;
    int unsigned mismatches = 0;

    function void write_reg(logic [tid_pkg::CfgIdxW-1:0] idx,
                            logic [tid_pkg::CfgDataW-1:0] data);
      case (idx)
        tid_pkg::CfgGridWidth:   grid_w = data;
        tid_pkg::CfgGridHeight:  grid_h = data;
        tid_pkg::CfgBlockWidth:  blk_w  = data[10:0];
        tid_pkg::CfgBlockHeight: blk_h  = data[10:0];
        tid_pkg::CfgBlockDepth:  blk_d  = data[6:0];
        default: ;
      endcase
    endfunction

    // zero acts as one, oversize saturates
    function longint unsigned clamp_dim(longint unsigned v, longint unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function longint unsigned grid_threads();
      return clamp_dim(grid_w, 65535) * clamp_dim(grid_h, 65535) *
             clamp_dim(blk_w, 1024) * clamp_dim(blk_h, 1024) * clamp_dim(blk_d, 64);
    endfunction

    function coords_t decompose(logic [31:0] flat);
      longint unsigned gw, gh, bw, bh, bd, tpb, blk, tib;
      coords_t c;
      gw  = clamp_dim(grid_w, 65535);
      gh  = clamp_dim(grid_h, 65535);
      bw  = clamp_dim(blk_w, 1024);
      bh  = clamp_dim(blk_h, 1024);
      bd  = clamp_dim(blk_d, 64);
      tpb = bw * bh * bd;
      blk = flat / tpb;
      tib = flat % tpb;
      c = '0;
      c.blk_x         = 16'(blk % gw);
      c.blk_y         = 16'((blk / gw) % gh);
      c.blk_z         = 32'(blk / (gw * gh));
      c.thr_x         = 10'(tib % bw);
      c.thr_y         = 10'((tib / bw) % bh);
      c.thr_z         = 6'(tib / (bw * bh));
      c.warp_number   = 21'(tib / WarpSize);
      c.lane_number   = 5'(tib % WarpSize);
      c.global_number = flat;
      return c;
    endfunction

    function void note_thread(logic [31:0] flat);
      expected_coords.push_back(decompose(flat));
    endfunction

    function int unsigned pending();
      return expected_coords.size();
    endfunction

    function void cmp_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch in %s of result %0d: expected 0x%0h, got 0x%0h",
                   name, checked, want, got);
      end
    endfunction

    function void check_coords(coords_t got);
      coords_t want;
      if (expected_coords.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result 0x%0h arrived with nothing pending", got);
        return;
      end
      want = expected_coords.pop_front();
      checked++;
      cmp_field("blk_x", want.blk_x, got.blk_x);
      cmp_field("blk_y", want.blk_y, got.blk_y);
      cmp_field("blk_z", want.blk_z, got.blk_z);
      cmp_field("thr_x", want.thr_x, got.thr_x);
      cmp_field("thr_y", want.thr_y, got.thr_y);
      cmp_field("thr_z", want.thr_z, got.thr_z);
      cmp_field("warp_number", want.warp_number, got.warp_number);
      cmp_field("lane_number", want.lane_number, got.lane_number);
      cmp_field("global_number", want.global_number, got.global_number);
      cmp_field("pad", want.pad, got.pad);
    endfunction
  endclass

  logic                          clk_i           = 1'b0;
  logic                          rst_ni          = 1'b0;
  logic [31:0]                   s_axis_tdata_i  = '0;
  logic                          s_axis_tvalid_i = 1'b0;
  logic                          s_axis_tready_o;
  logic [tid_pkg::OutW-1:0]      m_axis_tdata_o;
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i = 1'b0;
  logic                          cfg_valid_i     = 1'b0;
  logic                          cfg_ready_o;
  logic [tid_pkg::CfgIdxW-1:0]   cfg_index_i     = '0;
  logic [tid_pkg::CfgDataW-1:0]  cfg_data_i      = '0;

  decomp_board board;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned threads_sent   = 0;
  int unsigned reg_writes     = 0;
  int unsigned dim_settings   = 0;
  int unsigned cycles         = 0;
  int unsigned hold_left      = 0;
  logic        hold_toggle    = 1'b0;
  logic        hold_seen      = 1'b0;

  thread_index_decomposer #(
    .WARP_SIZE(WarpSize)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, board.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: check accepted items, then pick next tready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      hold_left       <= 0;
      hold_seen       <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) board.check_coords(m_axis_tdata_o);
      if (hold_toggle != hold_seen) begin
        hold_seen       <= hold_toggle;
        hold_left       <= HoldCycles;
        m_axis_tready_i <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left       <= hold_left - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_thread(input logic [31:0] flat);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= flat;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_thread(flat);
    threads_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // caller lowers cfg_valid_i after the last write of a batch
  task automatic cfg_write(input logic [tid_pkg::CfgIdxW-1:0] idx,
                           input logic [tid_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, data);
    reg_writes++;
  endtask

  task automatic set_dims(input logic [15:0] gw, input logic [15:0] gh,
                          input logic [15:0] bw, input logic [15:0] bh,
                          input logic [15:0] bd, input bit stray);
    wait_drained();
    if (stray) cfg_write(tid_pkg::CfgIdxW'($urandom_range(FirstUnusedIdx, NumIdx - 1)),
                         16'($urandom));
    cfg_write(tid_pkg::CfgGridWidth, gw);
    cfg_write(tid_pkg::CfgGridHeight, gh);
    cfg_write(tid_pkg::CfgBlockWidth, bw);
    cfg_write(tid_pkg::CfgBlockHeight, bh);
    cfg_write(tid_pkg::CfgBlockDepth, bd);
    cfg_valid_i <= 1'b0;
    dim_settings++;
  endtask

  function automatic logic [15:0] rand_grid();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [15:0] rand_blk(input int unsigned maxv);
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'(maxv);
      2:       return 16'($urandom);
      3:       return 16'(maxv + 1);
      default: return 16'($urandom_range(1, 8));
    endcase
  endfunction

  // in two of six cases inside about two launches of the grid so blk_z stays small
  function automatic logic [31:0] pick_flat();
    longint unsigned span;
    span = 2 * board.grid_threads();
    if (span > 32'hFFFF_FFFF) span = 32'hFFFF_FFFF;
    case ($urandom_range(5))
      0, 1:    return $urandom;
      2:       return $urandom_range(255);
      3:       return 32'hFFFF_FFFF - $urandom_range(255);
      default: return $urandom_range(32'(span));
    endcase
  endfunction

  initial begin
    board = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset dimensions: every thread is its own block
    send_thread(32'd0);
    send_thread(32'hFFFF_FFFF);
    send_thread(32'd1);

    // largest grid and block
    set_dims(16'hFFFF, 16'hFFFF, 16'd1024, 16'd1024, 16'd64, 1'b0);
    send_thread(32'd0);
    send_thread(32'hFFFF_FFFF);
    send_thread(32'h03FF_FFFF);
    send_thread(32'h0400_0000);
    send_thread(32'd31);
    send_thread(32'd32);

    // zero dimensions, also zero after the field mask
    set_dims(16'd0, 16'd0, 16'h0800, 16'd0, 16'h0080, 1'b0);
    send_thread(32'h8765_4321);
    send_thread(32'hFFFF_FFFF);

    // oversized block dimensions saturate
    set_dims(16'd3, 16'd5, 16'hFFFF, 16'h0401, 16'h007F, 1'b0);
    send_thread(32'h0FFF_FFFF);
    send_thread(32'hFFFF_FFFF);
    send_thread(32'h0400_0001);
    send_thread(32'h1234_5678);

    // small odd shape, crossing block and grid boundaries
    set_dims(16'd3, 16'd2, 16'd5, 16'd3, 16'd2, 1'b0);
    send_thread(32'd29);
    send_thread(32'd30);
    send_thread(32'd31);
    send_thread(32'd179);
    send_thread(32'd180);

    // writes to unused indexes must leave the shape alone
    wait_drained();
    for (int unsigned i = FirstUnusedIdx; i < NumIdx; i++)
      cfg_write(tid_pkg::CfgIdxW'(i), 16'hFFFF);
    cfg_valid_i <= 1'b0;
    send_thread(32'd200);

    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      set_dims(rand_grid(), rand_grid(), rand_blk(32'(tid_pkg::BlkDimMax)),
               rand_blk(32'(tid_pkg::BlkDimMax)), rand_blk(32'(tid_pkg::BlkDepMax)),
               $urandom_range(3) == 0);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      // long receiver hold while items keep coming, so the input backs up
      if (ph == 5) hold_toggle <= ~hold_toggle;
      for (int unsigned n = 0; n < ItemsPerPhase; n++) begin
        if (ph == 6 && n == ItemsPerPhase / 2) wait_drained();
        send_thread(pick_flat());
      end
    end

    wait_drained();
    recv_stall_pct = 0;
    repeat (TailCycles) @(posedge clk_i);

    $display("sent %0d thread numbers under %0d dimension settings (%0d register writes)",
             threads_sent, dim_settings, reg_writes);
    $display("checked %0d results, %0d field mismatches", board.checked, board.mismatches);
    if (board.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
